>>> design/thc_pkg.sv
// Shared types and constants for the twelve-hour clock with keypad set.
package thc_pkg;

  localparam logic       ActTick  = 1'b0;
  localparam logic       ActKey   = 1'b1;
  localparam logic [3:0] KeyStar  = 4'd14;
  localparam logic [3:0] KeyHash  = 4'd15;
  localparam logic [4:0] KeyEmpty = 5'd16;

  localparam logic [1:0] StageHour   = 2'd0;
  localparam logic [1:0] StageMinute = 2'd1;
  localparam logic [1:0] StageAmPm   = 2'd2;

  typedef struct packed {
    logic       action;
    logic [3:0] key_code;
  } in_item_t;

  typedef struct packed {
    logic [3:0] hour_now;
    logic [5:0] minute_now;
    logic [5:0] second_now;
    logic       is_pm;
    logic       in_setting;
    logic [1:0] set_stage;
    logic [4:0] entry_first;
    logic [4:0] entry_second;
    logic       entry_error;
  } out_item_t;

endpackage

>>> design/thc_stream_if.sv
// Valid/ready stream channel carrying one payload beat.
interface thc_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/thc_core.sv
// Clock and keypad-entry state with its single-pass next-state logic.
module thc_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  thc_pkg::in_item_t   item_i,
  output thc_pkg::out_item_t  res_o
);

  logic [3:0] hour_q,   hour_d;
  logic [5:0] minute_q, minute_d;
  logic [5:0] second_q, second_d;
  logic       pm_q,     pm_d;
  logic       set_q,    set_d;
  logic [1:0] stage_q,  stage_d;
  logic [1:0] cnt_q,    cnt_d;
  logic [4:0] key0_q,   key0_d;
  logic [4:0] key1_q,   key1_d;
  logic       hold_q,   hold_d;
  logic       err;

  logic [6:0] sec_w, min_w, val;
  logic [4:0] hour_w;

  // Decimal value of the one or two entered digits: 0..99.
  always_comb begin
    val = '0;
    if (key0_q <= 5'd9) begin
      val = {2'b00, key0_q};
      if (key1_q <= 5'd9) begin
        val = ({2'b00, key0_q} << 3) + ({2'b00, key0_q} << 1) + {2'b00, key1_q};
      end
    end
  end

  always_comb begin
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    pm_d     = pm_q;
    set_d    = set_q;
    stage_d  = stage_q;
    cnt_d    = cnt_q;
    key0_d   = key0_q;
    key1_d   = key1_q;
    hold_d   = hold_q;
    err      = 1'b0;
    sec_w    = {1'b0, second_q} + 7'd1;
    min_w    = {1'b0, minute_q};
    hour_w   = {1'b0, hour_q};

    if (item_i.action == thc_pkg::ActTick) begin
      if (!set_q) begin
        if (hold_q) begin
          // Resume tick: land seconds on zero, no carry.
          second_d = '0;
          hold_d   = 1'b0;
        end else begin
          if (sec_w >= 7'd60) begin
            min_w = min_w + 7'd1;
            sec_w = '0;
          end
          if (min_w >= 7'd60) begin
            hour_w = hour_w + 5'd1;
            min_w  = '0;
          end
          if (hour_w == 5'd12 && min_w == 7'd0 && sec_w == 7'd0) begin
            pm_d = ~pm_q;
          end else if (hour_w >= 5'd13) begin
            hour_w = 5'd1;
          end
          hour_d   = hour_w[3:0];
          minute_d = min_w[5:0];
          second_d = sec_w[5:0];
        end
      end
    end else if (!set_q) begin
      if (item_i.key_code == thc_pkg::KeyStar) begin
        set_d   = 1'b1;
        stage_d = thc_pkg::StageHour;
        cnt_d   = '0;
        key0_d  = thc_pkg::KeyEmpty;
        key1_d  = thc_pkg::KeyEmpty;
      end
    end else if (item_i.key_code == thc_pkg::KeyHash) begin
      case (stage_q)
        thc_pkg::StageHour: begin
          if (val >= 7'd1 && val <= 7'd12) begin
            hour_d  = val[3:0];
            stage_d = thc_pkg::StageMinute;
          end else begin
            err = 1'b1;
          end
        end
        thc_pkg::StageMinute: begin
          if (val <= 7'd59) begin
            minute_d = val[5:0];
            second_d = '0;
            hold_d   = 1'b1;
            stage_d  = thc_pkg::StageAmPm;
          end else begin
            err = 1'b1;
          end
        end
        default: begin
          if (val == 7'd1 || val == 7'd2) begin
            pm_d    = (val == 7'd2);
            set_d   = 1'b0;
            stage_d = thc_pkg::StageHour;
          end else begin
            err = 1'b1;
          end
        end
      endcase
      cnt_d  = '0;
      key0_d = thc_pkg::KeyEmpty;
      key1_d = thc_pkg::KeyEmpty;
    end else if (item_i.key_code != thc_pkg::KeyStar) begin
      if (cnt_q > 2'd1) begin
        err    = 1'b1;
        cnt_d  = '0;
        key0_d = thc_pkg::KeyEmpty;
        key1_d = thc_pkg::KeyEmpty;
      end else begin
        if (cnt_q[0]) begin
          key1_d = {1'b0, item_i.key_code};
        end else begin
          key0_d = {1'b0, item_i.key_code};
        end
        cnt_d = cnt_q + 2'd1;
      end
    end
  end

  always_comb begin
    res_o.hour_now     = hour_d;
    res_o.minute_now   = minute_d;
    res_o.second_now   = hold_d ? 6'd0 : second_d;
    res_o.is_pm        = pm_d;
    res_o.in_setting   = set_d;
    res_o.set_stage    = stage_d;
    res_o.entry_first  = key0_d;
    res_o.entry_second = key1_d;
    res_o.entry_error  = err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hour_q   <= 4'd12;
      minute_q <= '0;
      second_q <= '0;
      pm_q     <= 1'b0;
      set_q    <= 1'b0;
      stage_q  <= thc_pkg::StageHour;
      cnt_q    <= '0;
      key0_q   <= thc_pkg::KeyEmpty;
      key1_q   <= thc_pkg::KeyEmpty;
      hold_q   <= 1'b0;
    end else if (step_i) begin
      hour_q   <= hour_d;
      minute_q <= minute_d;
      second_q <= second_d;
      pm_q     <= pm_d;
      set_q    <= set_d;
      stage_q  <= stage_d;
      cnt_q    <= cnt_d;
      key0_q   <= key0_d;
      key1_q   <= key1_d;
      hold_q   <= hold_d;
    end
  end

endmodule

>>> design/twelve_hour_clock_with_keypad_set.sv
// Twelve-hour clock with AM/PM flag and keypad time setting.
//
// Each input beat is either a one-second tick or a key press; every beat
// yields exactly one result beat with the current time, the setting stage,
// the two entry slots and an error flag for that key. The block takes one
// beat per clock cycle while the sink keeps up. A beat lands in the input
// register; once the output register is free, the clock/entry state is
// updated in one pass of compare and increment logic and the result is
// loaded into the output register, which offers it to the sink. The output
// register holds a result while the sink stalls, and the input register
// keeps accepting while that result is still unread as long as the output
// register drains in the same cycle. Star stops the clock and opens hour
// entry; hash commits hour, then minute (seconds zeroed), then 1 = AM /
// 2 = PM, which restarts it. The first tick after that restart only lands
// seconds on zero.
module twelve_hour_clock_with_keypad_set (
  input  logic         clk_i,
  input  logic         rst_ni,
  thc_stream_if.sink   in_i,
  thc_stream_if.source out_o
);

  logic               in_vld_q;
  thc_pkg::in_item_t  in_item_q;
  logic               out_vld_q;
  thc_pkg::out_item_t out_item_q;
  thc_pkg::out_item_t res;
  logic               out_free;
  logic               step;
  logic               in_take;

  // Output register can take a new result when empty or draining now.
  assign out_free = !out_vld_q || out_o.ready;
  assign step     = in_vld_q && out_free;
  assign in_i.ready = !in_vld_q || out_free;
  assign in_take  = in_i.valid && in_i.ready;

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_item_q;

  thc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_item_q),
    .res_o  (res)
  );

  // Input stage: hold the beat until the core consumes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_i.data;
    end
  end

  // Result stage: drop the beat once the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_item_q <= res;
    end
  end

  // In run mode the entry slots are always empty.
  a_run_entry_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_item_q.in_setting |->
      out_item_q.entry_first == thc_pkg::KeyEmpty &&
      out_item_q.entry_second == thc_pkg::KeyEmpty)
    else $error("entry slots not empty in run mode");

  // A tick never raises an entry error.
  a_tick_no_error : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && in_item_q.action == thc_pkg::ActTick |=> !out_item_q.entry_error)
    else $error("entry error on a tick beat");

  // Hour stays within 1..12 and the stage never reaches three.
  a_hour_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> out_item_q.hour_now != 4'd0 && out_item_q.hour_now <= 4'd12 &&
      out_item_q.set_stage <= thc_pkg::StageAmPm)
    else $error("hour or stage out of range");

  // Minutes and seconds stay below sixty.
  a_min_sec_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> out_item_q.minute_now <= 6'd59 && out_item_q.second_now <= 6'd59)
    else $error("minute or second out of range");

  // Every consumed beat shows up as a result.
  a_step_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_vld_q)
    else $error("consumed beat produced no result");

endmodule
